/* hdl/fcc_pkg.sv */
`default_nettype none

package fcc_pkg;

   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_FOLLOW = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DATA_START  = 2'd0,
      CSR_SECT_PER_CL = 2'd1,
      CSR_TABLE_SIZE  = 2'd2
   } csr_index_type;

   localparam int ADDR_W      = 13;
   localparam int BYTE_W      = 8;
   localparam int CLUSTER_W   = 12;
   localparam int LINK_W      = 12;
   localparam int SECTOR_W    = 32;
   localparam int DSS_W       = 20;
   localparam int SPC_W       = 8;
   localparam int TSIZE_W     = 14;
   localparam int CSR_DATA_W  = 20;
   // wide enough for any table size in the supported parameter range
   localparam int CMP_W       = 17;
   localparam int PROD_W      = 22;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;
   localparam logic [LINK_W-1:0]    LINK_END_MIN       = 12'hFF7;

   typedef struct packed {
      cmd_type                 cmd;
      logic                    wr_ok;
      logic [ADDR_W-1:0]       address;
      logic [BYTE_W-1:0]       data;
      logic [ADDR_W-1:0]       offset;
      logic                    odd;
      logic                    oor;
      logic [ADDR_W-1:0]       cluster_m2;
   } entry_type;

endpackage

`default_nettype wire

/* hdl/fat12_cluster_chain_step_core.sv */
`default_nettype none

// FAT12 cluster chain step. A write request (command 0) stores one table byte;
// a follow request (command 1) returns the cluster's first sector, its 12-bit
// link and the chain-end and out-of-range flags. Requests are taken when start
// is high and busy is low, normally one per cycle; busy rises only when the
// two-entry request queue between the front and back end is full. Each request
// gives exactly one registered response, marked by rsp_valid for one cycle,
// and the receiver cannot hold it off. The rate is set by the table store:
// even and odd bytes sit in two banks with one read port each, so a byte pair
// is one lookup. The table has no reset and needs no clearing pass; follow
// requests must read only written entries. The user makes configuration writes
// (csr_ready is always high) only while the block is idle; it is not enforced.
module fat12_cluster_chain_step_core #(
   parameter int TABLE_BYTES = 8192
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_command,
   input  wire logic [fcc_pkg::ADDR_W-1:0]        req_table_address,
   input  wire logic [fcc_pkg::BYTE_W-1:0]        req_table_byte,
   input  wire logic [fcc_pkg::CLUSTER_W-1:0]     req_cluster,
   output logic                                   rsp_valid,
   output logic [fcc_pkg::SECTOR_W-1:0]           rsp_first_sector,
   output logic [fcc_pkg::LINK_W-1:0]             rsp_next_cluster,
   output logic                                   rsp_chain_end,
   output logic                                   rsp_out_of_range,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [fcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [fcc_pkg::DSS_W-1:0]   sector_base_ff, sector_base_in;
   logic [fcc_pkg::SPC_W-1:0]   spc_ff, spc_in;
   logic [fcc_pkg::TSIZE_W-1:0] tsize_ff, tsize_in;

   fcc_pkg::entry_type front_entry, head;
   logic push, pop, q_empty, q_full;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign push      = start && !q_full;
   assign pop       = !q_empty;

   always_comb begin
      sector_base_in = sector_base_ff;
      spc_in         = spc_ff;
      tsize_in       = tsize_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fcc_pkg::CSR_DATA_START:  sector_base_in = csr_wdata[fcc_pkg::DSS_W-1:0];
            fcc_pkg::CSR_SECT_PER_CL: spc_in         = csr_wdata[fcc_pkg::SPC_W-1:0];
            fcc_pkg::CSR_TABLE_SIZE:  tsize_in       = csr_wdata[fcc_pkg::TSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_base_ff <= '0;
         spc_ff         <= fcc_pkg::SPC_W'(1);
         tsize_ff       <= '0;
      end else begin
         sector_base_ff <= sector_base_in;
         spc_ff         <= spc_in;
         tsize_ff       <= tsize_in;
      end
   end

   fcc_front #(.TABLE_BYTES(TABLE_BYTES)) u_front (
      .req_command       (req_command),
      .req_table_address (req_table_address),
      .req_table_byte    (req_table_byte),
      .req_cluster       (req_cluster),
      .table_size        (tsize_ff),
      .entry             (front_entry)
   );

   fcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   fcc_back #(.TABLE_BYTES(TABLE_BYTES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop              (pop),
      .ent              (head),
      .sector_base      (sector_base_ff),
      .sect_per_cl      (spc_ff),
      .rsp_valid        (rsp_valid),
      .rsp_first_sector (rsp_first_sector),
      .rsp_next_cluster (rsp_next_cluster),
      .rsp_chain_end    (rsp_chain_end),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

`default_nettype wire

/* hdl/fcc_front.sv */
`default_nettype none

module fcc_front #(
   parameter int TABLE_BYTES = 8192
) (
   input  wire logic                          req_command,
   input  wire logic [fcc_pkg::ADDR_W-1:0]    req_table_address,
   input  wire logic [fcc_pkg::BYTE_W-1:0]    req_table_byte,
   input  wire logic [fcc_pkg::CLUSTER_W-1:0] req_cluster,
   input  wire logic [fcc_pkg::TSIZE_W-1:0]   table_size,
   output fcc_pkg::entry_type                 entry
);

   localparam logic [fcc_pkg::CMP_W-1:0] STORE_BYTES = fcc_pkg::CMP_W'(TABLE_BYTES);

   logic [fcc_pkg::CMP_W-1:0]  limit;
   logic [fcc_pkg::ADDR_W-1:0] offset;
   logic [fcc_pkg::CMP_W-1:0]  pair_end;

   always_comb begin
      limit = (fcc_pkg::CMP_W'(table_size) < STORE_BYTES) ?
              fcc_pkg::CMP_W'(table_size) : STORE_BYTES;
      // byte offset of the entry: cluster * 3 / 2
      offset   = fcc_pkg::ADDR_W'(req_cluster) + fcc_pkg::ADDR_W'(req_cluster >> 1);
      pair_end = fcc_pkg::CMP_W'(offset) + fcc_pkg::CMP_W'(1);

      entry.cmd        = fcc_pkg::cmd_type'(req_command);
      entry.wr_ok      = (fcc_pkg::CMP_W'(req_table_address) < STORE_BYTES);
      entry.address    = req_table_address;
      entry.data       = req_table_byte;
      entry.offset     = offset;
      entry.odd        = req_cluster[0];
      entry.oor        = (pair_end >= limit);
      entry.cluster_m2 = fcc_pkg::ADDR_W'(req_cluster) -
                         fcc_pkg::ADDR_W'(fcc_pkg::FIRST_DATA_CLUSTER);
   end

endmodule

`default_nettype wire

/* hdl/fcc_queue.sv */
`default_nettype none

module fcc_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire fcc_pkg::entry_type push_entry,
   input  wire logic          pop,
   output fcc_pkg::entry_type head,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = $clog2(fcc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(fcc_pkg::QUEUE_DEPTH + 1);

   fcc_pkg::entry_type slot_ff [fcc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(fcc_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(fcc_pkg::QUEUE_DEPTH - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

/* hdl/fcc_back.sv */
`default_nettype none

module fcc_back #(
   parameter int TABLE_BYTES = 8192
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         pop,
   input  wire fcc_pkg::entry_type           ent,
   input  wire logic [fcc_pkg::DSS_W-1:0]    sector_base,
   input  wire logic [fcc_pkg::SPC_W-1:0]    sect_per_cl,
   output logic                              rsp_valid,
   output logic [fcc_pkg::SECTOR_W-1:0]      rsp_first_sector,
   output logic [fcc_pkg::LINK_W-1:0]        rsp_next_cluster,
   output logic                              rsp_chain_end,
   output logic                              rsp_out_of_range
);

   localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
   localparam int BANK_IW    = $clog2(BANK_DEPTH);

   // even bytes in one bank, odd bytes in the other: a pair is one read per bank
   logic [fcc_pkg::BYTE_W-1:0] even_mem [BANK_DEPTH];
   logic [fcc_pkg::BYTE_W-1:0] odd_mem  [BANK_DEPTH];

   logic [BANK_IW-1:0] wr_idx, even_idx, odd_idx;
   logic               is_follow, rd_en;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_follow_ff, s1_oor_ff, s1_odd_ff, s1_lo_odd_ff;
   logic [fcc_pkg::BYTE_W-1:0]   even_rd_ff, odd_rd_ff;
   logic signed [fcc_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic [2*fcc_pkg::BYTE_W-1:0] pair;
   logic [fcc_pkg::LINK_W-1:0]   link;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fcc_pkg::SECTOR_W-1:0] sector_ff, sector_in;
   logic [fcc_pkg::LINK_W-1:0]   link_ff, link_in;
   logic                         end_ff, end_in;
   logic                         oor_ff, oor_in;

   always_comb begin
      is_follow = (ent.cmd == fcc_pkg::CMD_FOLLOW);
      rd_en     = pop && is_follow && !ent.oor;
      wr_idx    = BANK_IW'(ent.address >> 1);
      odd_idx   = BANK_IW'(ent.offset >> 1);
      even_idx  = BANK_IW'((fcc_pkg::CMP_W'(ent.offset) + fcc_pkg::CMP_W'(1)) >> 1);
      prod_in   = fcc_pkg::PROD_W'($signed(ent.cluster_m2) * $signed({1'b0, sect_per_cl}));
      s1_valid_in = pop;
   end

   always_ff @(posedge clock) begin
      if (pop && !is_follow && ent.wr_ok && !ent.address[0]) begin
         even_mem[wr_idx] <= ent.data;
      end
      if (rd_en) begin
         even_rd_ff <= even_mem[even_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !is_follow && ent.wr_ok && ent.address[0]) begin
         odd_mem[wr_idx] <= ent.data;
      end
      if (rd_en) begin
         odd_rd_ff <= odd_mem[odd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_follow_ff <= is_follow;
         s1_oor_ff    <= ent.oor;
         s1_odd_ff    <= ent.odd;
         s1_lo_odd_ff <= ent.offset[0];
         prod_ff      <= prod_in;
      end
   end

   always_comb begin
      pair = s1_lo_odd_ff ? {even_rd_ff, odd_rd_ff} : {odd_rd_ff, even_rd_ff};
      link = s1_odd_ff ? pair[15:4] : pair[11:0];

      rsp_valid_in = s1_valid_ff;
      sector_in    = '0;
      link_in      = '0;
      end_in       = 1'b0;
      oor_in       = 1'b0;
      if (s1_follow_ff) begin
         sector_in = fcc_pkg::SECTOR_W'(sector_base) +
                     {{(fcc_pkg::SECTOR_W - fcc_pkg::PROD_W){prod_ff[fcc_pkg::PROD_W-1]}},
                      prod_ff};
         oor_in    = s1_oor_ff;
         if (s1_oor_ff) begin
            end_in = 1'b1;
         end else begin
            link_in = link;
            end_in  = (link == '0) || (link >= fcc_pkg::LINK_END_MIN);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         sector_ff <= sector_in;
         link_ff   <= link_in;
         end_ff    <= end_in;
         oor_ff    <= oor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_sector = sector_ff;
   assign rsp_next_cluster = link_ff;
   assign rsp_chain_end    = end_ff;
   assign rsp_out_of_range = oor_ff;

`ifndef SYNTHESIS
   a_strobe_follows_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> ##2 rsp_valid_ff)
      else $error("request popped without a response two cycles later");

   a_oor_ends_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && oor_ff) |-> (end_ff && link_ff == '0))
      else $error("out-of-range response without chain end or with a link");

   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (pop && !(ent.cmd == fcc_pkg::CMD_WRITE)))
      else $error("table read issued for a write request");
`endif

endmodule

`default_nettype wire

/* sim/tb_fat12_cluster_chain_step_core.sv */
`timescale 1ns / 100ps

module tb_fat12_cluster_chain_step_core;

   localparam int TABLE_BYTES = 8192;
   localparam logic [fcc_pkg::LINK_W-1:0] CHAIN_END_MIN = 12'hFF7;
   localparam logic [fcc_pkg::SECTOR_W-1:0] FIRST_CLUSTER = 32'd2;

   typedef struct packed {
      logic [fcc_pkg::SECTOR_W-1:0] first_sector;
      logic [fcc_pkg::LINK_W-1:0]   next_cluster;
      logic                         chain_end;
      logic                         out_of_range;
   } link_result_type;

   // shadow of the allocation table and registers; predicts one response per request
   class link_scoreboard;
      logic [fcc_pkg::BYTE_W-1:0]  table_bytes [TABLE_BYTES];
      bit                          written [TABLE_BYTES];
      logic [fcc_pkg::DSS_W-1:0]   sector_base;
      logic [fcc_pkg::SPC_W-1:0]   sect_per_cl;
      logic [fcc_pkg::TSIZE_W-1:0] table_size;
      link_result_type             expected_links [$];
      int                          errors;

      function new();
         sector_base = '0;
         sect_per_cl = 8'd1;
         table_size  = '0;
         errors      = 0;
      endfunction

      function void set_reg(fcc_pkg::csr_index_type idx,
                            logic [fcc_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            fcc_pkg::CSR_DATA_START:  sector_base = value[fcc_pkg::DSS_W-1:0];
            fcc_pkg::CSR_SECT_PER_CL: sect_per_cl = value[fcc_pkg::SPC_W-1:0];
            fcc_pkg::CSR_TABLE_SIZE:  table_size  = value[fcc_pkg::TSIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned size_in_use();
         return (table_size > TABLE_BYTES) ? TABLE_BYTES : table_size;
      endfunction

      function void note_request(fcc_pkg::cmd_type cmd, logic [fcc_pkg::ADDR_W-1:0] addr,
                                 logic [fcc_pkg::BYTE_W-1:0] data,
                                 logic [fcc_pkg::CLUSTER_W-1:0] cluster);
         link_result_type r;
         bit [31:0]       offset;
         bit [15:0]       pair;
         r = '0;
         if (cmd == fcc_pkg::CMD_WRITE) begin
            table_bytes[addr] = data;
            written[addr] = 1'b1;
         end else begin
            r.first_sector = 32'(sector_base) + (32'(cluster) - FIRST_CLUSTER) * 32'(sect_per_cl);
            offset = 32'(cluster) + 32'(cluster >> 1);
            if (offset + 1 >= size_in_use()) begin
               r.out_of_range = 1'b1;
               r.chain_end = 1'b1;
            end else begin
               pair = {table_bytes[offset + 1], table_bytes[offset]};
               r.next_cluster = cluster[0] ? pair[15:4] : pair[11:0];
               r.chain_end = (r.next_cluster == '0) || (r.next_cluster >= CHAIN_END_MIN);
            end
         end
         expected_links.push_back(r);
      endfunction

      function void check_response(link_result_type got);
         link_result_type exp;
         if (expected_links.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected response sector %h link %h end %b oor %b", $time,
                        got.first_sector, got.next_cluster, got.chain_end, got.out_of_range);
            return;
         end
         exp = expected_links.pop_front();
         if (got.first_sector !== exp.first_sector || got.next_cluster !== exp.next_cluster ||
             got.chain_end !== exp.chain_end || got.out_of_range !== exp.out_of_range) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch exp sector %h link %h end %b oor %b, got %h %h %b %b",
                        $time, exp.first_sector, exp.next_cluster, exp.chain_end,
                        exp.out_of_range, got.first_sector, got.next_cluster, got.chain_end,
                        got.out_of_range);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_command = 1'b0;
   logic [fcc_pkg::ADDR_W-1:0] req_table_address = '0;
   logic [fcc_pkg::BYTE_W-1:0] req_table_byte = '0;
   logic [fcc_pkg::CLUSTER_W-1:0] req_cluster = '0;
   logic rsp_valid;
   logic [fcc_pkg::SECTOR_W-1:0] rsp_first_sector;
   logic [fcc_pkg::LINK_W-1:0] rsp_next_cluster;
   logic rsp_chain_end;
   logic rsp_out_of_range;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [fcc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   link_scoreboard ledger = new();

   fat12_cluster_chain_step_core #(
      .TABLE_BYTES(TABLE_BYTES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_table_address(req_table_address),
      .req_table_byte(req_table_byte),
      .req_cluster(req_cluster),
      .rsp_valid(rsp_valid),
      .rsp_first_sector(rsp_first_sector),
      .rsp_next_cluster(rsp_next_cluster),
      .rsp_chain_end(rsp_chain_end),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin : rsp_monitor
      link_result_type seen;
      if (!reset && rsp_valid) begin
         seen = {rsp_first_sector, rsp_next_cluster, rsp_chain_end, rsp_out_of_range};
         ledger.check_response(seen);
      end
   end

   task automatic issue(fcc_pkg::cmd_type cmd, logic [fcc_pkg::ADDR_W-1:0] addr,
                        logic [fcc_pkg::BYTE_W-1:0] data,
                        logic [fcc_pkg::CLUSTER_W-1:0] cluster, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_table_address <= addr;
      req_table_byte <= data;
      req_cluster <= cluster;
      do @(posedge clock); while (busy);
      ledger.note_request(cmd, addr, data, cluster);
   endtask

   task automatic write_byte(int unsigned addr, logic [fcc_pkg::BYTE_W-1:0] data,
                             int idle_pct);
      issue(fcc_pkg::CMD_WRITE, fcc_pkg::ADDR_W'(addr), data,
            fcc_pkg::CLUSTER_W'($urandom), idle_pct);
   endtask

   task automatic follow(logic [fcc_pkg::CLUSTER_W-1:0] cluster, int idle_pct);
      issue(fcc_pkg::CMD_FOLLOW, fcc_pkg::ADDR_W'($urandom), fcc_pkg::BYTE_W'($urandom),
            cluster, idle_pct);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (ledger.expected_links.size() != 0);
   endtask

   // leaves csr_valid high so back-to-back writes need not drop it in between
   task automatic write_reg(fcc_pkg::csr_index_type idx,
                            logic [fcc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      ledger.set_reg(idx, value);
   endtask

   task automatic configure(logic [fcc_pkg::DSS_W-1:0] dss, logic [fcc_pkg::SPC_W-1:0] spc,
                            logic [fcc_pkg::TSIZE_W-1:0] tsize);
      drain();
      write_reg(fcc_pkg::CSR_DATA_START, fcc_pkg::CSR_DATA_W'(dss));
      write_reg(fcc_pkg::CSR_SECT_PER_CL, fcc_pkg::CSR_DATA_W'(spc));
      write_reg(fcc_pkg::CSR_TABLE_SIZE, fcc_pkg::CSR_DATA_W'(tsize));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [fcc_pkg::LINK_W-1:0] pick_link();
      int r;
      r = $urandom_range(99);
      if (r < 12) return '0;
      if (r < 27) return fcc_pkg::LINK_W'($urandom_range(12'hFF7, 12'hFFF));
      if (r < 32) return 12'h001;
      if (r < 36) return 12'hFF6;
      return fcc_pkg::LINK_W'($urandom_range(2, 12'hFF6));
   endfunction

   function automatic logic [fcc_pkg::BYTE_W-1:0] shadow_byte(int unsigned addr);
      return ledger.written[addr] ? ledger.table_bytes[addr] : fcc_pkg::BYTE_W'($urandom);
   endfunction

   // mostly link placement followed by a lookup, often walking the chain; some noise
   task automatic run_phase(int items, int idle_pct);
      int issued;
      int r;
      int unsigned lim;
      int unsigned cmax;
      int unsigned off;
      logic [fcc_pkg::CLUSTER_W-1:0] c;
      logic [fcc_pkg::CLUSTER_W-1:0] hint;
      bit hint_ok;
      logic [fcc_pkg::LINK_W-1:0] link;
      logic [15:0] pair;
      link_result_type last;
      issued = 0;
      hint_ok = 1'b0;
      hint = '0;
      while (issued < items) begin
         if ($urandom_range(99) < 3) drain();
         r = $urandom_range(99);
         lim = ledger.size_in_use();
         if (r < 12) begin
            write_byte($urandom_range(0, TABLE_BYTES - 1), fcc_pkg::BYTE_W'($urandom),
                       idle_pct);
            issued++;
         end else begin
            cmax = (lim >= 2) ? (2 * (lim - 2) + 1) / 3 : 0;
            if (cmax > 4095) cmax = 4095;
            if (r < 22 || lim < 2)
               c = fcc_pkg::CLUSTER_W'($urandom_range(0, 4095));
            else if (hint_ok && hint <= cmax && $urandom_range(99) < 40)
               c = hint;
            else
               c = fcc_pkg::CLUSTER_W'($urandom_range(0, cmax));
            off = c + (c >> 1);
            if (off + 1 < lim &&
                (r >= 22 || !ledger.written[off] || !ledger.written[off + 1])) begin
               link = pick_link();
               pair = {shadow_byte(off + 1), shadow_byte(off)};
               if (c[0]) pair = {link, pair[3:0]};
               else pair = {pair[15:12], link};
               write_byte(off, pair[7:0], idle_pct);
               write_byte(off + 1, pair[15:8], idle_pct);
               issued += 2;
            end
            follow(c, idle_pct);
            issued++;
            last = ledger.expected_links[$];
            hint = last.next_cluster;
            hint_ok = !last.chain_end;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // registers at reset value: no table in use
      follow(12'd0, 0);
      follow(12'd4095, 0);

      configure(20'hFFFFF, 8'd128, 14'd6143);
      write_byte(8191, 8'hA5, 0);
      write_byte(0, 8'h00, 0);
      write_byte(1, 8'h00, 0);
      write_byte(2, 8'hFF, 0);
      follow(12'd0, 0);      // free link ends chain
      follow(12'd1, 0);      // 0xFF0 is still a link
      write_byte(3, 8'hFF, 0);
      write_byte(4, 8'h0F, 0);
      follow(12'd2, 0);      // 0xFFF
      write_byte(5, 8'h01, 0);
      follow(12'd3, 0);
      write_byte(6, 8'h00, 0);
      write_byte(7, 8'h70, 0);
      write_byte(8, 8'hFF, 0);
      follow(12'd5, 0);      // 0xFF7, lowest end marker
      follow(12'd4, 0);
      write_byte(7, 8'h60, 0);
      follow(12'd5, 0);      // 0xFF6, one below
      write_byte(6141, 8'h01, 0);
      write_byte(6142, 8'hF0, 0);
      follow(12'd4094, 0);   // last pair inside the table
      follow(12'd4095, 0);   // pair straddles the table end

      configure(20'd0, 8'd1, 14'd8192);
      run_phase(110, 14);
      configure(fcc_pkg::DSS_W'($urandom), 8'd255, 14'd16383);
      run_phase(110, 59);
      configure(20'hFFFFF, 8'd0, fcc_pkg::TSIZE_W'($urandom_range(2, 600)));
      run_phase(90, 0);
      configure(fcc_pkg::DSS_W'($urandom), 8'd128, 14'd0);
      run_phase(40, 14);
      configure(fcc_pkg::DSS_W'($urandom), fcc_pkg::SPC_W'($urandom_range(1, 128)),
                14'd6144);
      run_phase(80, 59);
      configure(20'd0, 8'd1, 14'd6143);
      run_phase(70, 0);

      drain();
      repeat (8) @(posedge clock);
      if (ledger.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
